[src/skt_pkg.sv]
// Shared types and constants for the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;
	localparam int DEPTH_DEF        = 64;
	localparam int PAYLOAD_BITS_DEF = 16;
	localparam int KEY_W            = 31;
	localparam int PL_W             = 16;
	localparam int CNT_W            = 7;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_FOUND     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic apply;
	} cmd_t;
endpackage

[src/skt_if.sv]
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface skt_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [30:0] key;
	logic [15:0] payload;
	modport source (output valid, operation, key, payload, input ready);
	modport sink (input valid, operation, key, payload, output ready);
endinterface

interface skt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] found_payload;
	logic [6:0]  entry_count;
	modport source (output valid, status, found_payload, entry_count, input ready);
	modport sink (input valid, status, found_payload, entry_count, output ready);
endinterface

[src/skt_ctrl.sv]
// Controller: sequences load, compare and apply for one transaction at a time.
`timescale 1ns / 1ps
module skt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output skt_pkg::cmd_t cmd
);
	import skt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.apply)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = S_APPLY;
			end
			S_APPLY: begin
				// wait until the output register is empty or being taken
				if (!out_valid_q || rsp_ready) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rsp_valid = out_valid_q;
endmodule

[src/skt_datapath.sv]
// Datapath: row of sorted key cells with parallel compare and shift insert.
`timescale 1ns / 1ps
module skt_datapath #(
	parameter int DEPTH        = skt_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  skt_pkg::cmd_t             cmd,
	input  logic                      operation,
	input  logic [skt_pkg::KEY_W-1:0] key,
	input  logic [skt_pkg::PL_W-1:0]  payload,
	output logic [1:0]                status,
	output logic [skt_pkg::PL_W-1:0]  found_payload,
	output logic [skt_pkg::CNT_W-1:0] entry_count
);
	import skt_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [KEY_W-1:0]        keys_q [DEPTH];
	logic [PAYLOAD_BITS-1:0] pls_q  [DEPTH];
	logic [CW-1:0]           count_q;
	logic                    op_q;
	logic [KEY_W-1:0]        key_q;
	logic [PAYLOAD_BITS-1:0] pl_q;
	logic [DEPTH-1:0]        le_s1, eq_s1;
	logic [DEPTH-1:0]        first_eq;
	logic [PAYLOAD_BITS-1:0] sel_pl;
	logic                    full, hit, do_insert;
	logic [63:0]             pl_wide, sel_wide;
	logic [1:0]              status_q;
	logic [PL_W-1:0]         found_q;

	assign pl_wide = 64'(payload);
	assign full    = (count_q == CW'(DEPTH));
	assign do_insert = cmd.apply && (op_q == OP_INSERT) && !full;

	// latch the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			key_q <= key;
			pl_q  <= pl_wide[PAYLOAD_BITS-1:0];
		end
	end

	// per-cell compare against the latched key
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < DEPTH; i++) begin
				le_s1[i] <= (CW'(i) < count_q) && (keys_q[i] <= key_q);
				eq_s1[i] <= (CW'(i) < count_q) && (keys_q[i] == key_q);
			end
		end
	end

	// lowest matching cell and its payload
	always_comb begin
		sel_pl = '0;
		for (int i = 0; i < DEPTH; i++) begin
			first_eq[i] = eq_s1[i] && ((i == 0) || !eq_s1[(i == 0) ? 0 : i - 1]);
			if (first_eq[i])
				sel_pl = sel_pl | pls_q[i];
		end
		hit = |first_eq;
	end
	assign sel_wide = 64'(sel_pl);

	// cell row: keep, take new entry, or shift up from the cell below
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_insert && !le_s1[g]) begin
				if (g == 0 || le_s1[(g == 0) ? 0 : g - 1]) begin
					keys_q[g] <= key_q;
					pls_q[g]  <= pl_q;
				end else begin
					keys_q[g] <= keys_q[(g == 0) ? 0 : g - 1];
					pls_q[g]  <= pls_q[(g == 0) ? 0 : g - 1];
				end
			end
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (do_insert)
			count_q <= count_q + CW'(1);
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (op_q == OP_INSERT) begin
				status_q <= full ? ST_FULL : ST_INSERTED;
				found_q  <= '0;
			end else begin
				status_q <= hit ? ST_FOUND : ST_NOT_FOUND;
				found_q  <= hit ? sel_wide[PL_W-1:0] : '0;
			end
		end
	end

	logic [CNT_W-1:0] count_out_q;
	always_ff @(posedge clk) begin
		if (cmd.apply)
			count_out_q <= CNT_W'(do_insert ? count_q + CW'(1) : count_q);
	end

	assign status        = status_q;
	assign found_payload = found_q;
	assign entry_count   = count_out_q;
endmodule

[src/sorted_key_table.sv]
// A request is latched on acceptance, compared against all cells in parallel, then applied; one item at a time.
// A new request is taken only after the last one is applied; apply waits while the response register is held.
// The response register lets the next request be taken while a response waits.
// Reset clears the entry count and control; cell contents are undefined until written.
// Top level of the sorted key table.
`timescale 1ns / 1ps
module sorted_key_table #(
	parameter int DEPTH        = skt_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);
	import skt_pkg::*;

	cmd_t cmd;

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	skt_datapath #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (req.operation),
		.key           (req.key),
		.payload       (req.payload),
		.status        (rsp.status),
		.found_payload (rsp.found_payload),
		.entry_count   (rsp.entry_count)
	);

	// one transaction in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while busy");

	// a full refusal reports a full table
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.entry_count == CNT_W'(DEPTH))
		else $error("full status with table not full");

	// payload is zero unless found
	a_pl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_FOUND |-> rsp.found_payload == '0)
		else $error("payload set without a match");

	// a compare is never directly followed by a load
	a_apply_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compare |=> !cmd.load)
		else $error("load during apply phase");
endmodule

[dv/tb.sv]
// Self-checking testbench for the sorted key table: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;
	import skt_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int N_RANDOM = 1730;

	typedef struct {
		logic        operation;
		logic [30:0] key;
		logic [15:0] payload;
		logic        checked;   // expected result typed in below
		logic [1:0]  status;
		logic [15:0] found_payload;
		logic [6:0]  entry_count;
	} row_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] found_payload;
		logic [6:0]  entry_count;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	skt_req_if req ();
	skt_rsp_if rsp ();

	sorted_key_table uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model of the table contents
	logic [30:0] table_keys[DEPTH];
	logic [15:0] table_payloads[DEPTH];
	int          table_used;

	result_t pending_results[$];
	result_t typed_results[$];
	logic    typed_valid[$];
	int      errors;
	int      n_results;
	int      n_found;
	int      n_full;
	bit      stim_done;

	function automatic result_t table_apply(logic op, logic [30:0] k, logic [15:0] pl);
		result_t r;
		int pos;
		r.found_payload = '0;
		if (op == OP_INSERT) begin
			if (table_used >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// stable insert: after every key that is smaller or equal
				pos = 0;
				while (pos < table_used && table_keys[pos] <= k)
					pos++;
				for (int i = table_used; i > pos; i--) begin
					table_keys[i] = table_keys[i - 1];
					table_payloads[i] = table_payloads[i - 1];
				end
				table_keys[pos] = k;
				table_payloads[pos] = pl;
				table_used++;
				r.status = ST_INSERTED;
			end
		end else begin
			r.status = ST_NOT_FOUND;
			for (int i = 0; i < table_used; i++)
				if (table_keys[i] == k) begin
					r.status = ST_FOUND;
					r.found_payload = table_payloads[i];
					break;
				end
		end
		r.entry_count = 7'(table_used);
		return r;
	endfunction

	// Directed rows
	row_t directed[$];

	function automatic void add_row(logic op, logic [30:0] k, logic [15:0] pl,
			logic chk = 1'b0, logic [1:0] st = '0, logic [15:0] fp = '0,
			logic [6:0] cnt = '0);
		row_t r;
		r.operation = op; r.key = k; r.payload = pl; r.checked = chk;
		r.status = st; r.found_payload = fp; r.entry_count = cnt;
		directed.push_back(r);
	endfunction

	// Random key, mostly from narrow pools so that lookups and duplicates hit often
	function automatic logic [30:0] pick_key();
		case ($urandom_range(0, 3))
			0: return 31'($urandom);
			1: return 31'h7FFF_FFF0 + 31'($urandom_range(0, 15));
			default: return 31'($urandom_range(0, 40));
		endcase
	endfunction

	task automatic send_one(logic op, logic [30:0] k, logic [15:0] pl);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.key <= k;
		req.payload <= pl;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_results.push_back(table_apply(op, k, pl));
	endtask

	// Response side: random stall, compare against oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		logic    typed;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.found_payload, rsp.entry_count};
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected response status=%0d payload=%h count=%0d",
						$time, got.status, got.found_payload, got.entry_count);
					errors++;
				end else begin
					want = pending_results.pop_front();
					typed = 1'b0;
					if (typed_valid.size() > 0) begin
						typed = typed_valid.pop_front();
						if (typed) want = typed_results.pop_front();
					end
					n_results++;
					if (got.status == ST_FOUND) n_found++;
					if (got.status == ST_FULL) n_full++;
					if (got.status != want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
						errors++;
					end
					if (got.found_payload != want.found_payload) begin
						$display("%0t: found_payload expected %h actual %h", $time,
							want.found_payload, got.found_payload);
						errors++;
					end
					if (got.entry_count != want.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d", $time,
							want.entry_count, got.entry_count);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 19) == 0)
				rsp.ready <= ($urandom_range(0, 1) == 0);
			else if ($urandom_range(0, 3) == 0)
				rsp.ready <= 1'b1;
		end
	end

	// Stimulus
	initial begin
		int wait_cycles;
		logic [15:0] pl;
		req.valid = 1'b0;
		req.operation = OP_INSERT;
		req.key = '0;
		req.payload = '0;
		rsp.ready = 1'b1;
		errors = 0; n_results = 0; n_found = 0; n_full = 0; stim_done = 0;
		table_used = 0;

		// lookup on empty table, extremes, duplicates keep arrival order
		add_row(OP_LOOKUP, 31'd0, 16'hFFFF, 1'b1, ST_NOT_FOUND, 16'h0, 7'd0);
		add_row(OP_INSERT, 31'h7FFF_FFFF, 16'hFFFF, 1'b1, ST_INSERTED, 16'h0, 7'd1);
		add_row(OP_INSERT, 31'd0, 16'h0000, 1'b1, ST_INSERTED, 16'h0, 7'd2);
		add_row(OP_INSERT, 31'd5, 16'hAAAA);
		add_row(OP_INSERT, 31'd5, 16'h5555);
		add_row(OP_LOOKUP, 31'd5, 16'h1234);
		add_row(OP_LOOKUP, 31'h7FFF_FFFF, 16'h0, 1'b1, ST_FOUND, 16'hFFFF, 7'd4);
		add_row(OP_LOOKUP, 31'd0, 16'hFFFF, 1'b1, ST_FOUND, 16'h0000, 7'd4);
		add_row(OP_LOOKUP, 31'd6, 16'h0);
		add_row(OP_LOOKUP, 31'h5555_5555, 16'hFFFF);
		add_row(OP_INSERT, 31'h2AAA_AAAA, 16'h8001);
		add_row(OP_LOOKUP, 31'h2AAA_AAAA, 16'h0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			typed_valid.push_back(directed[i].checked);
			if (directed[i].checked)
				typed_results.push_back('{directed[i].status,
					directed[i].found_payload, directed[i].entry_count});
			send_one(directed[i].operation, directed[i].key, directed[i].payload);
		end

		// fill to full, provoke refusals, then keep looking up
		for (int n = 0; n < N_RANDOM; n++) begin
			pl = 16'($urandom);
			if (n < 600 && table_used < DEPTH && $urandom_range(0, 2) != 0)
				send_one(OP_INSERT, pick_key(), pl);
			else
				send_one(1'($urandom_range(0, 2) == 0 ? OP_INSERT : OP_LOOKUP), pick_key(), pl);
		end
		req.valid <= 1'b0;

		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		$display("Ran %0d transactions: %0d lookups hit, %0d inserts refused on a full table.",
			n_results, n_found, n_full);
		if (errors == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
